@@ rtl/core/jd2cal_pkg.sv @@
// Widths, constants and lookup tables for the Julian Date to calendar date pipeline.
// No dependencies; imported by julian_day_to_calendar_date.
package jd2cal_pkg;

    // Input format: DAY_BITS integer bits, FRAC_BITS fraction bits
    localparam int DAY_BITS  = 23;
    localparam int FRAC_BITS = 20;
    localparam int JD_W      = DAY_BITS + FRAC_BITS;

    // Output field widths
    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 21;
    localparam int HOUR_FRAC = 16;

    localparam int STAGES = 8;

    // Calendar constants
    localparam longint unsigned HALF_DAY   = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned GREG_START = 64'd2299161;
    localparam longint unsigned B_NUM_OFF  = 64'd7468865;   // 4 * 1867216.25
    localparam longint unsigned B_DEN      = 64'd146097;    // 4 * 36524.25
    localparam longint unsigned C_OFF_GREG = 64'd1525;
    localparam longint unsigned C_OFF_JUL  = 64'd1524;
    localparam longint unsigned D_OFF      = 64'd2442;      // 20 * 122.1
    localparam longint unsigned D_DEN      = 64'd7305;      // 20 * 365.25
    localparam longint unsigned E_MUL      = 64'd1461;      // 4 * 365.25
    localparam longint unsigned YEAR_OFF   = 64'd4715;
    localparam longint unsigned HOURS_DAY  = 64'd24;

    // Day number, century term numerator and its reciprocal
    localparam int A_W  = DAY_BITS + 1;
    localparam int N1_W = A_W + 2;
    localparam longint unsigned M1 = (64'd1 << N1_W) / B_DEN;
    localparam int M1_W = $clog2(M1 + 64'd1);
    localparam int B_W  = M1_W;

    // Shifted day count and year term numerator with its reciprocal
    localparam int C_W  = DAY_BITS + 1;
    localparam int N2_W = C_W + 5;
    localparam longint unsigned M2 = (64'd1 << N2_W) / D_DEN;
    localparam int M2_W = $clog2(M2 + 64'd1);
    localparam int D_W  = M2_W;

    // Day within the March-based year and month index
    localparam int E_W  = D_W + 9;
    localparam int XS_W = (C_W > E_W) ? C_W : E_W;
    localparam int X_W  = 9;
    localparam int F_W  = 5;
    localparam int F_MAX = 16;
    localparam int YR_W = (D_W + 1 > YEAR_W) ? D_W + 1 : YEAR_W;

    localparam logic [F_W-1:0]     F_WRAP    = F_W'(14);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    // floor(30.6001 * f)
    function automatic logic [X_W-1:0] day_offset(input logic [F_W-1:0] f);
        logic [X_W-1:0] v;
        case (f)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/julian_day_to_calendar_date.sv @@
// Julian Date to calendar date conversion, eight-stage pipeline.
// Each transaction is registered in stages 0 to 7 in turn; the outputs come from the stage 7 registers.
// Throughput: one transaction per cycle while date_stall is low; stalls collapse bubbles stage by stage.
// The stage chain includes two constant-reciprocal divisions, each a multiply then a
// correction stage. Reset clears all stage valid bits; payload is not reset.
// Depends on jd2cal_pkg.
module julian_day_to_calendar_date (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 jd_valid,
    output logic                                 jd_stall,
    input  logic [jd2cal_pkg::JD_W-1:0]          julian_date,
    output logic                                 date_valid,
    input  logic                                 date_stall,
    output logic signed [jd2cal_pkg::YEAR_W-1:0] year_number,
    output logic [jd2cal_pkg::MONTH_W-1:0]       month_number,
    output logic [jd2cal_pkg::DAY_W-1:0]         day_of_month,
    output logic [jd2cal_pkg::HOUR_W-1:0]        hour_of_day
);
    import jd2cal_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   adv;

    logic [HOUR_W-1:0] hr_reg [STAGES];

    // stage 0
    logic [JD_W:0]              t;
    logic [FRAC_BITS+4:0]       f24;
    logic [FRAC_BITS+20:0]      hour_wide;
    logic [A_W-1:0]             a0_reg;
    // stage 1
    logic                       greg_s1;
    logic [N1_W-1:0]            n1;
    logic [N1_W+M1_W-1:0]       p1;
    logic [A_W-1:0]             a1_reg;
    logic                       greg1_reg;
    logic [N1_W-1:0]            n1_reg;
    logic [B_W-1:0]             q1_reg;
    // stage 2
    logic [B_W+17:0]            qd1;
    logic [N1_W-1:0]            r1;
    logic [A_W-1:0]             a2_reg;
    logic                       greg2_reg;
    logic [B_W-1:0]             b2_reg;
    // stage 3
    logic [C_W-1:0]             c_s3;
    logic [C_W-1:0]             c3_reg;
    // stage 4
    logic [N2_W-1:0]            n2;
    logic [N2_W+M2_W-1:0]       p2;
    logic [C_W-1:0]             c4_reg;
    logic [N2_W-1:0]            n2_reg;
    logic [D_W-1:0]             q2_reg;
    // stage 5
    logic [D_W+12:0]            qd2;
    logic [N2_W-1:0]            r2;
    logic [C_W-1:0]             c5_reg;
    logic [D_W-1:0]             d5_reg;
    // stage 6
    logic [D_W+10:0]            de;
    logic [XS_W-1:0]            xs;
    logic [X_W-1:0]             x6_reg;
    logic [D_W-1:0]             d6_reg;
    // stage 7
    logic [F_MAX-1:0]           ge;
    logic [F_W-1:0]             f;
    logic [MONTH_W-1:0]         month_s7;
    logic [X_W-1:0]             dom_s7;
    logic signed [YR_W-1:0]     yr_s7;
    logic signed [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]         month_reg;
    logic [DAY_W-1:0]           dom_reg;

    // ---------------- flow control ----------------
    always_comb
    begin
        adv[STAGES] = !date_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? jd_valid : v_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign jd_stall = !adv[0];

    // ---------------- datapath ----------------
    always_comb
    begin
        // add half a day; integer part is the day number
        t         = (JD_W+1)'(julian_date) + (JD_W+1)'(HALF_DAY);
        f24       = ((FRAC_BITS+5)'(t[FRAC_BITS-1:0]) << 4)
                  + ((FRAC_BITS+5)'(t[FRAC_BITS-1:0]) << 3);
        hour_wide = {f24, HOUR_FRAC'(0)} >> FRAC_BITS;

        // century term: approximate quotient by reciprocal
        greg_s1 = ({1'b0, a0_reg} >= (A_W+1)'(GREG_START));
        n1      = {a0_reg, 2'b00} - N1_W'(B_NUM_OFF);
        p1      = (N1_W+M1_W)'(n1) * (N1_W+M1_W)'(M1);

        // correct quotient by one where the remainder overflows
        qd1 = (B_W+18)'(q1_reg) * (B_W+18)'(B_DEN);
        r1  = n1_reg - N1_W'(qd1);

        if (greg2_reg)
        begin
            c_s3 = C_W'(a2_reg) + C_W'(b2_reg) - C_W'(b2_reg >> 2) + C_W'(C_OFF_GREG);
        end
        else
        begin
            c_s3 = C_W'(a2_reg) + C_W'(C_OFF_JUL);
        end

        // year term: 20c - 2442 over 7305
        n2 = (N2_W'(c3_reg) << 4) + (N2_W'(c3_reg) << 2) - N2_W'(D_OFF);
        p2 = (N2_W+M2_W)'(n2) * (N2_W+M2_W)'(M2);

        qd2 = (D_W+13)'(q2_reg) * (D_W+13)'(D_DEN);
        r2  = n2_reg - N2_W'(qd2);

        // days into the March-based year
        de = (D_W+11)'(d5_reg) * (D_W+11)'(E_MUL);
        xs = XS_W'(c5_reg) - XS_W'(de[D_W+10:2]);

        // month index: count thresholds ceil(30.6001 k) passed
        for (int k = 1; k <= F_MAX; k++)
        begin
            ge[k-1] = (x6_reg >= day_offset(F_W'(k)) + X_W'(1));
        end
        f      = F_W'($countones(ge));
        dom_s7 = x6_reg - day_offset(f);
        if (f < F_WRAP)
        begin
            month_s7 = MONTH_W'(f - F_W'(1));
        end
        else
        begin
            month_s7 = MONTH_W'(f - F_W'(13));
        end
        yr_s7 = $signed(YR_W'(d6_reg)) - $signed(YR_W'(YEAR_OFF))
              - $signed(YR_W'(month_s7 > MONTH_FEB));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a0_reg    <= t[JD_W:FRAC_BITS];
            hr_reg[0] <= hour_wide[HOUR_W-1:0];
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (adv[i])
            begin
                hr_reg[i] <= hr_reg[i-1];
            end
        end
        if (adv[1])
        begin
            a1_reg    <= a0_reg;
            greg1_reg <= greg_s1;
            n1_reg    <= n1;
            q1_reg    <= p1[N1_W +: B_W];
        end
        if (adv[2])
        begin
            a2_reg    <= a1_reg;
            greg2_reg <= greg1_reg;
            b2_reg    <= (r1 >= N1_W'(B_DEN)) ? q1_reg + B_W'(1) : q1_reg;
        end
        if (adv[3])
        begin
            c3_reg <= c_s3;
        end
        if (adv[4])
        begin
            c4_reg <= c3_reg;
            n2_reg <= n2;
            q2_reg <= p2[N2_W +: D_W];
        end
        if (adv[5])
        begin
            c5_reg <= c4_reg;
            d5_reg <= (r2 >= N2_W'(D_DEN)) ? q2_reg + D_W'(1) : q2_reg;
        end
        if (adv[6])
        begin
            x6_reg <= xs[X_W-1:0];
            d6_reg <= d5_reg;
        end
        if (adv[7])
        begin
            year_reg  <= yr_s7[YEAR_W-1:0];
            month_reg <= month_s7;
            dom_reg   <= DAY_W'(dom_s7);
        end
    end

    assign date_valid   = v_reg[STAGES-1];
    assign year_number  = year_reg;
    assign month_number = month_reg;
    assign day_of_month = dom_reg;
    assign hour_of_day  = hr_reg[STAGES-1];

    // ---------------- assertions ----------------
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        jd_stall |-> (&v_reg))
        else $error("input stalled while a pipeline stage is empty");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STAGES-2] && adv[STAGES-1]) |=> v_reg[STAGES-1])
        else $error("transaction lost entering the output stage");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-2] |-> (x6_reg >= X_W'(123) && x6_reg <= X_W'(489)))
        else $error("day-of-year term out of range");

    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (month_number >= MONTH_W'(1) && month_number <= MONTH_W'(12)))
        else $error("month out of range");

    a_day_hour: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (day_of_month != DAY_W'(0)
                        && hour_of_day < HOUR_W'(HOURS_DAY << HOUR_FRAC)))
        else $error("day or hour out of range");

endmodule
